// ----- rtl/obm_pkg.sv -----
// Shared constants, types and codes for the online bivariate moments block.
`timescale 1ns / 1ps
package obm_pkg;

   // Number formats
   localparam int FRAC_BITS   = 16;   // fraction bits of the variance/covariance outputs
   localparam int COUNT_WIDTH = 32;   // sample counter width
   localparam int GUARD       = 16;   // extra fraction bits kept on the means

   localparam int SAMPLE_W    = 32;
   localparam int COUNT_OUT_W = 32;
   localparam int VAR_OUT_W   = 48;
   localparam int MEAN_W      = SAMPLE_W + GUARD;   // mean accumulators
   localparam int DIFF_W      = MEAN_W + 1;         // sample minus mean
   localparam int STAT_W      = 64;                 // variance and co-moment accumulators

   // Bit-serial multiply/divide unit
   localparam int MCAND_W     = STAT_W;
   localparam int MPLIER_W    = MEAN_W;
   localparam int PROD_W      = 2 * MEAN_W;
   localparam int MD_ACC_W    = MCAND_W + MPLIER_W;
   localparam int MD_CNT_W    = $clog2(PROD_W + 1);

   // Operations run on the multiply/divide unit for one request, in order
   typedef enum logic [2:0] {
      OP_MEAN_A,
      OP_VAR_A_INC,
      OP_VAR_A_OLD,
      OP_COV_INC,
      OP_COV_OLD,
      OP_VAR_B_INC,
      OP_VAR_B_OLD,
      OP_MEAN_B
   } op_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_ISSUE,
      CS_WAIT,
      CS_RESULT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

   typedef struct packed {
      logic   req_ready;
      logic   start;
      logic   writeback;
      logic   load_out;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic                   start;
      logic                   use_mul;
      logic [MCAND_W-1:0]     mcand;
      logic [MPLIER_W-1:0]    mplier;
      logic [COUNT_WIDTH-1:0] divisor;
   } md_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quot;
   } md_rsp_type;

endpackage

// ----- rtl/obm_if.sv -----
// Request and response channel interfaces of the online bivariate moments block.
`timescale 1ns / 1ps
interface obm_req_if;
   import obm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_a;
   logic signed [SAMPLE_W-1:0] sample_b;

   modport source (output valid, output sample_a, output sample_b, input ready);
   modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

interface obm_rsp_if;
   import obm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [COUNT_OUT_W-1:0]      sample_count;
   logic signed [SAMPLE_W-1:0]  mean_a;
   logic signed [SAMPLE_W-1:0]  mean_b;
   logic [VAR_OUT_W-1:0]        variance_a;
   logic [VAR_OUT_W-1:0]        variance_b;
   logic signed [VAR_OUT_W-1:0] covariance_ab;

   modport source (output valid, output sample_count, output mean_a, output mean_b,
                   output variance_a, output variance_b, output covariance_ab,
                   input ready);
   modport sink   (input valid, input sample_count, input mean_a, input mean_b,
                   input variance_a, input variance_b, input covariance_ab,
                   output ready);
endinterface

// ----- rtl/obm_muldiv.sv -----
// Bit-serial unit: floor(mcand * mplier / divisor) or floor(mcand / divisor), one bit per cycle.
`timescale 1ns / 1ps
module obm_muldiv (
   input  logic              clock,
   input  logic              reset,
   input  obm_pkg::md_cmd_type cmd,
   output obm_pkg::md_rsp_type rsp
);
   import obm_pkg::*;

   md_state_type state_ff, state_in;
   logic [MD_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MD_ACC_W-1:0]    acc_ff, acc_in;
   logic [MCAND_W-1:0]     mcand_ff, mcand_in;
   logic [COUNT_WIDTH-1:0] div_ff, div_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;

   logic load, mul_step, div_step, mul_last, div_last;
   logic [MCAND_W:0]       mul_sum;
   logic [COUNT_WIDTH:0]   rem_shift, rem_diff;
   logic                   rem_ge;

   assign mul_last = (cnt_ff == MD_CNT_W'(MPLIER_W - 1));
   assign div_last = (cnt_ff == MD_CNT_W'(PROD_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (cmd.start) state_in = cmd.use_mul ? MD_MUL : MD_DIV;
         end
         MD_MUL: begin
            if (mul_last) state_in = MD_DIV;
         end
         MD_DIV: begin
            if (div_last) state_in = MD_DONE;
         end
         MD_DONE: begin
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load     = 1'b0;
      mul_step = 1'b0;
      div_step = 1'b0;
      rsp.done = 1'b0;
      rsp.quot = acc_ff[PROD_W-1:0];
      unique case (state_ff)
         MD_IDLE: load     = cmd.start;
         MD_MUL:  mul_step = 1'b1;
         MD_DIV:  div_step = 1'b1;
         MD_DONE: rsp.done = 1'b1;
         default: load     = 1'b0;
      endcase
   end

   // shift-add multiply, multiplier consumed LSB first from the low end of acc
   assign mul_sum = {1'b0, acc_ff[MD_ACC_W-1:MPLIER_W]}
                  + (acc_ff[0] ? {1'b0, mcand_ff} : {(MCAND_W + 1){1'b0}});

   // restoring division over the low PROD_W bits, MSB first
   assign rem_shift = {rem_ff, acc_ff[PROD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   always_comb begin
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (load) begin
         cnt_in   = '0;
         mcand_in = cmd.mcand;
         div_in   = cmd.divisor;
         rem_in   = '0;
         acc_in   = cmd.use_mul ? {{MCAND_W{1'b0}}, cmd.mplier} : MD_ACC_W'(cmd.mcand);
      end else if (mul_step) begin
         cnt_in = mul_last ? '0 : cnt_ff + 1'b1;
         acc_in = {mul_sum, acc_ff[MPLIER_W-1:1]};
      end else if (div_step) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = rem_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
         acc_in = {acc_ff[MD_ACC_W-1:PROD_W], acc_ff[PROD_W-2:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == MD_IDLE)
      else $error("muldiv started while busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> cmd.divisor != '0)
      else $error("muldiv started with zero divisor");

endmodule

// ----- rtl/obm_ctrl.sv -----
// Sequencer that steps one request through its multiply/divide operations.
`timescale 1ns / 1ps
module obm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   input  logic              md_done,
   input  logic              n_ge2,
   output obm_pkg::ctrl_type ctrl
);
   import obm_pkg::*;

   ctrl_state_type state_ff, state_in;
   op_type         op_ff, op_in, op_next;

   // operation order; the first sample only updates the means
   always_comb begin
      unique case (op_ff)
         OP_MEAN_A:    op_next = n_ge2 ? OP_VAR_A_INC : OP_MEAN_B;
         OP_VAR_A_INC: op_next = OP_VAR_A_OLD;
         OP_VAR_A_OLD: op_next = OP_COV_INC;
         OP_COV_INC:   op_next = OP_COV_OLD;
         OP_COV_OLD:   op_next = OP_VAR_B_INC;
         OP_VAR_B_INC: op_next = OP_VAR_B_OLD;
         OP_VAR_B_OLD: op_next = OP_MEAN_B;
         OP_MEAN_B:    op_next = OP_MEAN_A;
         default:      op_next = OP_MEAN_A;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_ISSUE;
               op_in    = OP_MEAN_A;
            end
         end
         CS_ISSUE: begin
            state_in = CS_WAIT;
         end
         CS_WAIT: begin
            if (md_done) begin
               state_in = (op_ff == OP_MEAN_B) ? CS_RESULT : CS_ISSUE;
               op_in    = op_next;
            end
         end
         CS_RESULT: begin
            if (out_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      ctrl.req_ready = 1'b0;
      ctrl.start     = 1'b0;
      ctrl.writeback = 1'b0;
      ctrl.load_out  = 1'b0;
      ctrl.op        = op_ff;
      unique case (state_ff)
         CS_IDLE:   ctrl.req_ready = 1'b1;
         CS_ISSUE:  ctrl.start     = 1'b1;
         CS_WAIT:   ctrl.writeback = md_done;
         CS_RESULT: ctrl.load_out  = out_free;
         default:   ctrl.req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         op_ff    <= OP_MEAN_A;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      md_done |-> state_ff == CS_WAIT)
      else $error("muldiv result arrived outside wait state");

   a_moment_ops_need_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_WAIT && op_ff != OP_MEAN_A && op_ff != OP_MEAN_B) |-> n_ge2)
      else $error("moment update run with fewer than two samples");

endmodule

// ----- rtl/online_bivariate_moments_unit.sv -----
// Top level: running means, variances and covariance of a sample pair (Welford update).
//
// Usage: each request on req_bus carries one pair (sample_a, sample_b) in signed
// Q16.16. For every request one response leaves on rsp_bus with the saturating
// sample count, both running means, both sample variances (unsigned Q32.16) and
// the sample covariance (signed Q32.16, zero until two samples are in).
// Both channels use valid/ready; a transfer happens when both are high.
// The block works on one request at a time: it takes no new request until the
// response to the last one is registered, and can take the next one from then on.
// All work runs on the single bit-serial multiply/divide unit: eight
// operations per request (two for the first sample after reset), each 48 multiply
// steps, 96 divide steps and a hand-over through the issue and done states (the
// two mean updates skip the multiply steps).
// Reset (synchronous, active high) clears the count and all accumulators.
// If the receiver stalls, the response stays in the output register; the block
// still takes and works on the next request and holds its result until the
// output register frees up.
`timescale 1ns / 1ps
module online_bivariate_moments_unit (
   input  logic      clock,
   input  logic      reset,
   obm_req_if.sink   req_bus,
   obm_rsp_if.source rsp_bus
);
   import obm_pkg::*;

   localparam logic [STAT_W-1:0] SMAX     = {1'b0, {(STAT_W - 1){1'b1}}};
   localparam logic [STAT_W-1:0] NEG_SMAX = {1'b1, {(STAT_W - 2){1'b0}}, 1'b1};
   localparam logic signed [STAT_W:0] SMAX_X     = $signed({1'b0, SMAX});
   localparam logic signed [STAT_W:0] NEG_SMAX_X = $signed({1'b1, NEG_SMAX});

   function automatic logic signed [DIFF_W-1:0] scale_sample(
      input logic signed [SAMPLE_W-1:0] s);
      return $signed({{(DIFF_W - SAMPLE_W - GUARD){s[SAMPLE_W-1]}}, s, {GUARD{1'b0}}});
   endfunction

   function automatic logic [MEAN_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] m;
      m = v[DIFF_W-1] ? (~v + 1'b1) : v;
      return m[MEAN_W-1:0];
   endfunction

   function automatic logic [VAR_OUT_W-1:0] var_out(input logic [STAT_W-1:0] v);
      logic [STAT_W-1:0] s;
      s = v >> FRAC_BITS;
      return (|s[STAT_W-1:VAR_OUT_W]) ? {VAR_OUT_W{1'b1}} : s[VAR_OUT_W-1:0];
   endfunction

   function automatic logic [VAR_OUT_W-1:0] cov_out(input logic signed [STAT_W-1:0] v);
      logic signed [STAT_W-1:0] s;
      logic [STAT_W-VAR_OUT_W:0] top;
      s   = v >>> FRAC_BITS;
      top = s[STAT_W-1:VAR_OUT_W-1];
      if ((&top) || !(|top)) return s[VAR_OUT_W-1:0];
      return s[STAT_W-1] ? {1'b1, {(VAR_OUT_W - 1){1'b0}}}
                         : {1'b0, {(VAR_OUT_W - 1){1'b1}}};
   endfunction

   ctrl_type   ctrl;
   md_cmd_type md_cmd;
   md_rsp_type md_rsp;

   // state
   logic [COUNT_WIDTH-1:0]     n_ff;
   logic signed [MEAN_W-1:0]   ma_ff, mb_ff, mean_next;
   logic [STAT_W-1:0]          va_ff, vb_ff, var_next;
   logic signed [STAT_W-1:0]   cov_ff, cov_next;
   logic signed [SAMPLE_W-1:0] xa_ff, xb_ff;
   logic signed [DIFF_W-1:0]   da_ff, da_in;
   logic [STAT_W-1:0]          inc_ff, inc_in;
   logic                       rsp_valid_ff;

   // output register
   logic [COUNT_OUT_W-1:0]      count_out_ff;
   logic signed [SAMPLE_W-1:0]  mean_a_out_ff, mean_b_out_ff;
   logic [VAR_OUT_W-1:0]        var_a_out_ff, var_b_out_ff;
   logic signed [VAR_OUT_W-1:0] cov_out_ff;

   logic req_fire, out_free, n_ge2;
   logic [COUNT_WIDTH-1:0]   n_m1, n_m2, n_inc;
   logic signed [DIFF_W-1:0] ea, db, d_sel;
   logic [MEAN_W-1:0]        mag_da, mag_db, mag_ea;
   logic [STAT_W-1:0]        cov_mag;
   logic [PROD_W-1:0]        q;

   logic signed [MEAN_W-1:0] m_sel;
   logic [DIFF_W-1:0]        qm, step, mean_sum;
   logic [STAT_W:0]          var_sum;
   logic [STAT_W-1:0]        om, im;
   logic signed [STAT_W:0]   o_s, t_s, s_s;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign n_ge2    = (n_ff > COUNT_WIDTH'(1));
   assign n_m1     = n_ff - 1'b1;
   assign n_m2     = n_ff - 2'd2;
   assign n_inc    = (n_ff == {COUNT_WIDTH{1'b1}}) ? n_ff : n_ff + 1'b1;

   assign da_in   = scale_sample(req_bus.sample_a) - $signed({ma_ff[MEAN_W-1], ma_ff});
   // ea uses the already updated mean of a, db the not yet updated mean of b
   assign ea      = scale_sample(xa_ff) - $signed({ma_ff[MEAN_W-1], ma_ff});
   assign db      = scale_sample(xb_ff) - $signed({mb_ff[MEAN_W-1], mb_ff});
   assign mag_da  = mag_of(da_ff);
   assign mag_db  = mag_of(db);
   assign mag_ea  = mag_of(ea);
   assign cov_mag = cov_ff[STAT_W-1] ? (~cov_ff + 1'b1) : cov_ff;
   assign q       = md_rsp.quot;

   obm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .out_free  (out_free),
      .md_done   (md_rsp.done),
      .n_ge2     (n_ge2),
      .ctrl      (ctrl)
   );

   // operand selection for the multiply/divide unit
   always_comb begin
      md_cmd.start   = ctrl.start;
      md_cmd.use_mul = 1'b1;
      md_cmd.mcand   = '0;
      md_cmd.mplier  = '0;
      md_cmd.divisor = n_ff;
      unique case (ctrl.op)
         OP_MEAN_A: begin
            md_cmd.use_mul = 1'b0;
            md_cmd.mcand   = MCAND_W'(mag_da);
         end
         OP_VAR_A_INC: begin
            md_cmd.mcand  = MCAND_W'(mag_da);
            md_cmd.mplier = mag_da;
         end
         OP_VAR_A_OLD: begin
            md_cmd.mcand   = va_ff;
            md_cmd.mplier  = MPLIER_W'(n_m2);
            md_cmd.divisor = n_m1;
         end
         OP_COV_INC: begin
            md_cmd.mcand   = MCAND_W'(mag_ea);
            md_cmd.mplier  = mag_db;
            md_cmd.divisor = n_m1;
         end
         OP_COV_OLD: begin
            md_cmd.mcand   = cov_mag;
            md_cmd.mplier  = MPLIER_W'(n_m2);
            md_cmd.divisor = n_m1;
         end
         OP_VAR_B_INC: begin
            md_cmd.mcand  = MCAND_W'(mag_db);
            md_cmd.mplier = mag_db;
         end
         OP_VAR_B_OLD: begin
            md_cmd.mcand   = vb_ff;
            md_cmd.mplier  = MPLIER_W'(n_m2);
            md_cmd.divisor = n_m1;
         end
         OP_MEAN_B: begin
            md_cmd.use_mul = 1'b0;
            md_cmd.mcand   = MCAND_W'(mag_db);
         end
         default: md_cmd.use_mul = 1'b1;
      endcase
   end

   obm_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .rsp   (md_rsp)
   );

   // mean update: quotient truncated toward zero, sign of the difference applied
   always_comb begin
      d_sel    = (ctrl.op == OP_MEAN_A) ? da_ff : db;
      m_sel    = (ctrl.op == OP_MEAN_A) ? ma_ff : mb_ff;
      qm       = q[DIFF_W-1:0];
      step     = d_sel[DIFF_W-1] ? (~qm + 1'b1) : qm;
      mean_sum = {m_sel[MEAN_W-1], m_sel} + step;
      mean_next = mean_sum[MEAN_W-1:0];
   end

   // increment term is the quotient with the guard fraction bits dropped
   assign inc_in = q[2*GUARD +: STAT_W];

   // variance: scaled old value plus increment, saturating
   always_comb begin
      var_sum  = {1'b0, q[STAT_W-1:0]} + {1'b0, inc_ff};
      var_next = var_sum[STAT_W] ? {STAT_W{1'b1}} : var_sum[STAT_W-1:0];
   end

   // covariance: signed sum of magnitudes, saturating symmetric
   always_comb begin
      om  = (|q[PROD_W-1:STAT_W-1]) ? SMAX : q[STAT_W-1:0];
      im  = inc_ff[STAT_W-1] ? SMAX : inc_ff;
      o_s = cov_ff[STAT_W-1] ? -$signed({1'b0, om}) : $signed({1'b0, om});
      t_s = (ea[DIFF_W-1] != db[DIFF_W-1]) ? -$signed({1'b0, im}) : $signed({1'b0, im});
      s_s = o_s + t_s;
      if (s_s > SMAX_X) begin
         cov_next = $signed(SMAX);
      end else if (s_s < NEG_SMAX_X) begin
         cov_next = $signed(NEG_SMAX);
      end else begin
         cov_next = s_s[STAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         ma_ff        <= '0;
         mb_ff        <= '0;
         va_ff        <= '0;
         vb_ff        <= '0;
         cov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) n_ff <= n_inc;
         if (ctrl.writeback) begin
            case (ctrl.op)
               OP_MEAN_A:    ma_ff  <= mean_next;
               OP_VAR_A_OLD: va_ff  <= var_next;
               OP_COV_OLD:   cov_ff <= cov_next;
               OP_VAR_B_OLD: vb_ff  <= var_next;
               OP_MEAN_B:    mb_ff  <= mean_next;
               default:      ;
            endcase
         end
         if (ctrl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         xa_ff <= req_bus.sample_a;
         xb_ff <= req_bus.sample_b;
         da_ff <= da_in;
      end
      if (ctrl.writeback && (ctrl.op inside {OP_VAR_A_INC, OP_COV_INC, OP_VAR_B_INC})) begin
         inc_ff <= inc_in;
      end
      if (ctrl.load_out) begin
         count_out_ff  <= COUNT_OUT_W'(n_ff);
         mean_a_out_ff <= ma_ff[GUARD +: SAMPLE_W];
         mean_b_out_ff <= mb_ff[GUARD +: SAMPLE_W];
         var_a_out_ff  <= var_out(va_ff);
         var_b_out_ff  <= var_out(vb_ff);
         cov_out_ff    <= cov_out(cov_ff);
      end
   end

   assign req_bus.ready         = ctrl.req_ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.sample_count  = count_out_ff;
   assign rsp_bus.mean_a        = mean_a_out_ff;
   assign rsp_bus.mean_b        = mean_b_out_ff;
   assign rsp_bus.variance_a    = var_a_out_ff;
   assign rsp_bus.variance_b    = var_b_out_ff;
   assign rsp_bus.covariance_ab = cov_out_ff;

   a_moments_zero_below_two: assert property (@(posedge clock) disable iff (reset)
      (n_ff <= COUNT_WIDTH'(1)) |-> (cov_ff == '0 && va_ff == '0 && vb_ff == '0))
      else $error("moments nonzero with fewer than two samples");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("response overwritten before it was taken");

endmodule
